// File: rtl/fcbc_pkg.sv
// ----------------------------------------------------------------------------
// fcbc_pkg: shared types, constants and helpers of the Feistel CBC cipher
// Field widths, register indexes, round-count saturation, and half-block and key rotations.
// ----------------------------------------------------------------------------
`default_nettype none

package fcbc_pkg;

  localparam int DATA_W     = 64;
  localparam int HALF_W     = 32;
  localparam int KEY_W      = 64;
  localparam int RC_W       = 5;
  localparam int CNT_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam int MAX_ROUNDS = 16;
  localparam int ROT_F      = 9;
  localparam int ROT_K      = 11;
  localparam int KEY_STEP   = 4;
  localparam int SUBKEY_LSB = 5;

  localparam int QUEUE_DEPTH_DEF = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CIPHER_KEY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VECTOR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 2'd3;

  localparam logic [RC_W-1:0] ROUND_COUNT_RST = 5'd2;

  typedef struct packed {
    logic [DATA_W-1:0] data_block;
    logic              first_block;
  } fcbc_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]  cipher_key;
    logic [RC_W-1:0]   round_count;
    logic [DATA_W-1:0] init_vector;
    logic              decrypt_mode;
  } fcbc_cfg_t;

  // Last round index: rounds saturate to 1..MAX_ROUNDS
  function automatic logic [CNT_W-1:0] last_round(input logic [RC_W-1:0] rc);
    logic [CNT_W-1:0] res;
    if (rc == '0) begin
      res = '0;
    end else if (rc > RC_W'(MAX_ROUNDS)) begin
      res = CNT_W'(MAX_ROUNDS - 1);
    end else begin
      res = CNT_W'(rc - 5'd1);
    end
    return res;
  endfunction

  // Rotate the key right by KEY_STEP times a round index
  function automatic logic [KEY_W-1:0] key_rotr(input logic [KEY_W-1:0] v,
                                                input logic [CNT_W-1:0] idx);
    logic [2*KEY_W-1:0] dbl;
    dbl = {v, v} >> (idx * KEY_STEP);
    return dbl[KEY_W-1:0];
  endfunction

  function automatic logic [HALF_W-1:0] rotl32(input logic [HALF_W-1:0] v,
                                               input int n);
    return (v << n) | (v >> (HALF_W - n));
  endfunction

  function automatic logic [HALF_W-1:0] rotr32(input logic [HALF_W-1:0] v,
                                               input int n);
    return (v >> n) | (v << (HALF_W - n));
  endfunction

endpackage

`default_nettype wire

// File: rtl/fcbc_queue.sv
// ----------------------------------------------------------------------------
// fcbc_queue: front request queue
// Accepts requests from the input channel and holds them for the round engine.
// ----------------------------------------------------------------------------
`default_nettype none

module fcbc_queue #(
  parameter int DEPTH = fcbc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push_valid,
  output logic                push_stall,
  input  fcbc_pkg::fcbc_item_t push_item,
  output logic                pop_valid,
  input  wire                 pop_take,
  output fcbc_pkg::fcbc_item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fcbc_pkg::fcbc_item_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic push, pop;

  assign push_stall = (count_r == CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && pop_take;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Payload storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/fcbc_round.sv
// ----------------------------------------------------------------------------
// fcbc_round: one Feistel round
// New left is the old right; new right is left xor F(right, subkey).
// ----------------------------------------------------------------------------
`default_nettype none

module fcbc_round (
  input  wire  [fcbc_pkg::HALF_W-1:0] l_in,
  input  wire  [fcbc_pkg::HALF_W-1:0] r_in,
  input  wire  [fcbc_pkg::HALF_W-1:0] subkey,
  output logic [fcbc_pkg::HALF_W-1:0] l_out,
  output logic [fcbc_pkg::HALF_W-1:0] r_out
);

  logic [fcbc_pkg::HALF_W-1:0] f_val;

  assign f_val = fcbc_pkg::rotl32(r_in, fcbc_pkg::ROT_F)
               ^ ~(fcbc_pkg::rotr32(subkey, fcbc_pkg::ROT_K) ^ r_in);
  assign l_out = r_in;
  assign r_out = l_in ^ f_val;

endmodule

`default_nettype wire

// File: rtl/fcbc_engine.sv
// ----------------------------------------------------------------------------
// fcbc_engine: back-end round sequencer with CBC chaining
// Runs one round per cycle, applies the chain and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcbc_engine (
  input  wire                                clk,
  input  wire                                rst_n,
  input  fcbc_pkg::fcbc_cfg_t                cfg,
  input  wire                                q_valid,
  output logic                               q_take,
  input  fcbc_pkg::fcbc_item_t               q_item,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [fcbc_pkg::DATA_W-1:0]        out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [fcbc_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [fcbc_pkg::HALF_W-1:0]  l_r, l_nxt, r_r, r_nxt;
  logic [fcbc_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic                         dec_r, dec_nxt;
  logic                         chain_en_r, chain_en_nxt;
  logic [fcbc_pkg::DATA_W-1:0]  link_r, link_nxt;
  logic [fcbc_pkg::DATA_W-1:0]  din_r, din_nxt;
  logic [fcbc_pkg::DATA_W-1:0]  chain_r, chain_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [fcbc_pkg::DATA_W-1:0]  out_data_r, out_data_nxt;

  logic [fcbc_pkg::HALF_W-1:0]  rl_out, rr_out;
  logic [fcbc_pkg::DATA_W-1:0]  fin_res, chain_new, chain_view, link_sel, x_blk;
  logic [fcbc_pkg::CNT_W-1:0]   last_idx;
  logic                         out_free, fire_done, load, chain_on;

  fcbc_round u_round (
    .l_in   (l_r),
    .r_in   (r_r),
    .subkey (key_r[fcbc_pkg::SUBKEY_LSB +: fcbc_pkg::HALF_W]),
    .l_out  (rl_out),
    .r_out  (rr_out)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign fire_done = (state_r == ST_DONE) && out_free;
  assign load      = q_valid && ((state_r == ST_IDLE) || fire_done);
  assign q_take    = load;

  // Undo the final swap and apply the decrypt-side chain
  assign fin_res   = {r_r, l_r}
                   ^ ((dec_r && chain_en_r) ? link_r : '0);
  assign chain_new = dec_r ? din_r : fin_res;
  // Forward the chain value being retired in the same cycle as the next load
  assign chain_view = (state_r == ST_DONE) ? chain_new : chain_r;

  assign chain_on = (cfg.init_vector != '0);
  assign link_sel = q_item.first_block ? cfg.init_vector : chain_view;
  assign x_blk    = (!cfg.decrypt_mode && chain_on) ? (q_item.data_block ^ link_sel)
                                                    : q_item.data_block;
  assign last_idx = fcbc_pkg::last_round(cfg.round_count);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    key_nxt       = key_r;
    dec_nxt       = dec_r;
    chain_en_nxt  = chain_en_r;
    link_nxt      = link_r;
    din_nxt       = din_r;
    chain_nxt     = chain_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_RUN: begin
        l_nxt   = rl_out;
        r_nxt   = rr_out;
        key_nxt = dec_r ? {key_r[fcbc_pkg::KEY_W-fcbc_pkg::KEY_STEP-1:0],
                           key_r[fcbc_pkg::KEY_W-1 -: fcbc_pkg::KEY_STEP]}
                        : {key_r[fcbc_pkg::KEY_STEP-1:0],
                           key_r[fcbc_pkg::KEY_W-1:fcbc_pkg::KEY_STEP]};
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = fin_res;
          chain_nxt     = chain_new;
          state_nxt     = ST_IDLE;
        end
      end
      ST_IDLE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Load the next request; decryption starts from the last subkey
    if (load) begin
      state_nxt    = ST_RUN;
      cnt_nxt      = last_idx;
      l_nxt        = x_blk[fcbc_pkg::DATA_W-1:fcbc_pkg::HALF_W];
      r_nxt        = x_blk[fcbc_pkg::HALF_W-1:0];
      key_nxt      = cfg.decrypt_mode ? fcbc_pkg::key_rotr(cfg.cipher_key, last_idx)
                                      : cfg.cipher_key;
      dec_nxt      = cfg.decrypt_mode;
      chain_en_nxt = chain_on;
      link_nxt     = link_sel;
      din_nxt      = q_item.data_block;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chain_r     <= chain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    l_r        <= l_nxt;
    r_r        <= r_nxt;
    key_r      <= key_nxt;
    dec_r      <= dec_nxt;
    chain_en_r <= chain_en_nxt;
    link_r     <= link_nxt;
    din_r      <= din_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/feistel_cbc_block_cipher_top.sv
// ----------------------------------------------------------------------------
// feistel_cbc_block_cipher_top: 64-bit Feistel block cipher with CBC chaining
// Request queue in front of a one-round-per-cycle engine.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one request carries a 64-bit block
//   and a first-block flag that restarts the chain from the IV. A request is
//   taken when in_valid is high and in_stall is low; in_stall rises only
//   while the front queue is full.
//   Result channel (out_valid / out_stall): one 64-bit block per request, in
//   request order. While out_stall is high the result holds; the engine
//   finishes its current block and waits, and the queue keeps taking requests
//   until it fills.
//   Configuration (cfg_we / cfg_index / cfg_wdata): key, round count, IV and
//   mode; write only while the block is idle.
//   Each request passes from the queue through the engine rounds into the
//   result register (round count saturated to 1..16). The engine works on
//   one block at a time with the single round unit that it reuses each
//   cycle; chaining makes each block depend on the previous ciphertext.
//   Reset (synchronous, active low): empties the queue, drops any block in
//   flight, clears the chain to zero and restores register defaults
//   (round count 2, encrypt, zero key and IV).
// ----------------------------------------------------------------------------
`default_nettype none

module feistel_cbc_block_cipher_top #(
  parameter int QUEUE_DEPTH = fcbc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [fcbc_pkg::DATA_W-1:0]        in_data_block,
  input  wire                                in_first_block,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [fcbc_pkg::DATA_W-1:0]        out_result_block,
  input  wire                                cfg_we,
  input  wire  [fcbc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [fcbc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  fcbc_pkg::fcbc_cfg_t  cfg_r, cfg_nxt;
  fcbc_pkg::fcbc_item_t in_item, q_item;
  logic                 q_valid, q_take;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        fcbc_pkg::REG_CIPHER_KEY:   cfg_nxt.cipher_key   = cfg_wdata;
        fcbc_pkg::REG_ROUND_COUNT:  cfg_nxt.round_count  = cfg_wdata[fcbc_pkg::RC_W-1:0];
        fcbc_pkg::REG_INIT_VECTOR:  cfg_nxt.init_vector  = cfg_wdata;
        fcbc_pkg::REG_DECRYPT_MODE: cfg_nxt.decrypt_mode = cfg_wdata[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cipher_key   <= '0;
      cfg_r.round_count  <= fcbc_pkg::ROUND_COUNT_RST;
      cfg_r.init_vector  <= '0;
      cfg_r.decrypt_mode <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_item.data_block  = in_data_block;
  assign in_item.first_block = in_first_block;

  // Front: hold accepted requests
  fcbc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_stall (in_stall),
    .push_item  (in_item),
    .pop_valid  (q_valid),
    .pop_take   (q_take),
    .pop_item   (q_item)
  );

  // Back: rounds, chaining and result register
  fcbc_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_take    (q_take),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_result_block)
  );

endmodule

`default_nettype wire

// File: rtl/fcbc_checker.sv
// ----------------------------------------------------------------------------
// fcbc_checker: port-level checks of the cipher top level
// Reset behavior of both channels and result hold under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module fcbc_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_stall,
  input wire                              out_valid,
  input wire                              out_stall,
  input wire [fcbc_pkg::DATA_W-1:0]       out_result_block
);

  // Reset drops any pending result
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Reset empties the request queue
  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_result_block))
    else $error("stalled result changed");

endmodule

bind feistel_cbc_block_cipher_top fcbc_checker u_fcbc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_result_block (out_result_block)
);

`default_nettype wire

// File: verif/fcbc_cipher_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbc_cipher_checker: result predictor and comparator for the Feistel CBC core
// Watches the configuration port and both the request and result channels, keeps its own
// copy of the registers and the chain, and checks each result in order.
// ----------------------------------------------------------------------------

module fcbc_cipher_checker (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  input  wire                             in_stall,
  input  wire  [fcbc_pkg::DATA_W-1:0]     in_data_block,
  input  wire                             in_first_block,
  input  wire                             out_valid,
  input  wire                             out_stall,
  input  wire  [fcbc_pkg::DATA_W-1:0]     out_result_block,
  input  wire                             cfg_we,
  input  wire  [fcbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [fcbc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              pending
);

  import fcbc_pkg::*;

  logic [KEY_W-1:0]  key_q;
  logic [RC_W-1:0]   rounds_q;
  logic [DATA_W-1:0] iv_q;
  logic              decrypt_q;
  logic [DATA_W-1:0] chain_q;
  logic [DATA_W-1:0] expected_blocks[$];

  // Round count saturates to 1..MAX_ROUNDS
  function automatic int round_total(input logic [RC_W-1:0] rc);
    if (rc == '0) return 1;
    if (rc > RC_W'(MAX_ROUNDS)) return MAX_ROUNDS;
    return int'(rc);
  endfunction

  function automatic logic [HALF_W-1:0] round_subkey(input logic [KEY_W-1:0] key,
                                                     input int idx);
    logic [KEY_W-1:0] rot;
    int               shift;
    shift = KEY_STEP * idx;
    if (shift == 0) rot = key;
    else rot = (key >> shift) | (key << (KEY_W - shift));
    return rot[SUBKEY_LSB +: HALF_W];
  endfunction

  // rotl(r, 9) ^ ~(rotr(k, 11) ^ r)
  function automatic logic [HALF_W-1:0] mix_half(input logic [HALF_W-1:0] r,
                                                 input logic [HALF_W-1:0] k);
    logic [HALF_W-1:0] r_rot, k_rot;
    r_rot = {r[HALF_W-1-ROT_F:0], r[HALF_W-1:HALF_W-ROT_F]};
    k_rot = {k[ROT_K-1:0], k[HALF_W-1:ROT_K]};
    return r_rot ^ ~(k_rot ^ r);
  endfunction

  function automatic logic [DATA_W-1:0] feistel_rounds(input logic [DATA_W-1:0] blk,
                                                       input logic reverse);
    logic [HALF_W-1:0] lhalf, rhalf, nxt;
    int                total, idx;
    lhalf = blk[DATA_W-1:HALF_W];
    rhalf = blk[HALF_W-1:0];
    total = round_total(rounds_q);
    for (int i = 0; i < total; i++) begin
      idx   = reverse ? total - 1 - i : i;
      nxt   = lhalf ^ mix_half(rhalf, round_subkey(key_q, idx));
      lhalf = rhalf;
      rhalf = nxt;
    end
    return {rhalf, lhalf};
  endfunction

  always @(posedge clk) begin : track
    logic [DATA_W-1:0] link, mixed, want;
    int                fails_now;
    fails_now = 0;
    if (!rst_n) begin
      key_q     = '0;
      rounds_q  = ROUND_COUNT_RST;
      iv_q      = '0;
      decrypt_q = 1'b0;
      chain_q   = '0;
      expected_blocks.delete();
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CIPHER_KEY:   key_q     = cfg_wdata[KEY_W-1:0];
          REG_ROUND_COUNT:  rounds_q  = cfg_wdata[RC_W-1:0];
          REG_INIT_VECTOR:  iv_q      = cfg_wdata[DATA_W-1:0];
          REG_DECRYPT_MODE: decrypt_q = cfg_wdata[0];
          default: ;
        endcase
      end
      // Compare before pushing: a result never leaves in its request's cycle
      if (out_valid && !out_stall) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: result_block with nothing outstanding: expected none, actual %h",
                   $time, out_result_block);
          fails_now++;
        end else begin
          want = expected_blocks.pop_front();
          if (out_result_block !== want) begin
            $display("%0t: result_block mismatch: expected %h, actual %h",
                     $time, want, out_result_block);
            fails_now++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        link = in_first_block ? iv_q : chain_q;
        if (decrypt_q) begin
          mixed = feistel_rounds(in_data_block, 1'b1);
          if (iv_q != '0) mixed = mixed ^ link;
          chain_q = in_data_block;
        end else begin
          mixed = feistel_rounds((iv_q != '0) ? (in_data_block ^ link) : in_data_block,
                                 1'b0);
          chain_q = mixed;
        end
        expected_blocks.insert(expected_blocks.size(), mixed);
      end
    end
    fail_count <= fail_count + fails_now;
    pending    <= expected_blocks.size();
  end

endmodule

// File: verif/feistel_cbc_block_cipher_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feistel_cbc_block_cipher_top_test: stimulus and verdict for the Feistel CBC core
// Directed corner requests, then randomized register settings with message
// sequences sent in bursts against a stalling receiver; the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------

module feistel_cbc_block_cipher_top_test;

  import fcbc_pkg::*;

  localparam int ITEM_TARGET = 1200;
  localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

  // Receiver stall styles that the back-pressure process switches between
  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [DATA_W-1:0]     in_data_block = '0;
  logic                  in_first_block = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DATA_W-1:0]     out_result_block;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int requests_sent = 0;

  stall_style_t stall_style = STALL_NONE;
  int           stall_cycle = 0;

  feistel_cbc_block_cipher_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_block    (in_data_block),
    .in_first_block   (in_first_block),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_block (out_result_block),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // The checker sees exactly what the core sees and reports back
  fcbc_cipher_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_block    (in_data_block),
    .in_first_block   (in_first_block),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_block (out_result_block),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver back-pressure: hold a style, then pick the next one at random.
  // The periodic style puts stalls on a fixed beat so they land on every
  // phase of the round engine; the no-stall style gives clean stretches.
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    unique case (stall_style)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
      default:        out_stall <= (stall_cycle[3:2] == 2'b11);
    endcase
    if (stall_cycle % 300 == 299) stall_style <= stall_style_t'($urandom_range(0, 3));
  end

  // Present one request and hold it until the core takes it. Valid stays
  // high on return so a burst can chain straight into the next request.
  task automatic send_request(input logic [DATA_W-1:0] blk, input logic first);
    in_valid       <= 1'b1;
    in_data_block  <= blk;
    in_first_block <= first;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  // Step the clock before checking so the checker's count reflects the last
  // accepted request, then hold until every expected result is back.
  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  // Leaves cfg_we high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] rand_block();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return ALL_ONES;
    return {$urandom, $urandom};
  endfunction

  // Favor the saturation corners, otherwise any legal count
  function automatic logic [CFG_DATA_W-1:0] rand_rounds();
    unique case ($urandom_range(0, 7))
      0:       return CFG_DATA_W'(0);
      1:       return CFG_DATA_W'(1);
      2:       return CFG_DATA_W'(MAX_ROUNDS);
      3:       return CFG_DATA_W'(MAX_ROUNDS + 1);
      4:       return CFG_DATA_W'(31);
      default: return CFG_DATA_W'($urandom_range(1, MAX_ROUNDS));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_iv();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return '0;      // chaining off
    if (pick == 3) return ALL_ONES;
    return {$urandom, $urandom};
  endfunction

  // Rewrite a random subset of the registers, at least one of them
  task automatic randomize_settings();
    logic touched;
    touched = 1'b0;
    if ($urandom_range(0, 1)) begin
      write_reg(REG_CIPHER_KEY, rand_block());
      touched = 1'b1;
    end
    if ($urandom_range(0, 1)) begin
      write_reg(REG_ROUND_COUNT, rand_rounds());
      touched = 1'b1;
    end
    if ($urandom_range(0, 1)) begin
      write_reg(REG_INIT_VECTOR, rand_iv());
      touched = 1'b1;
    end
    if ($urandom_range(0, 1) || !touched) begin
      write_reg(REG_DECRYPT_MODE, CFG_DATA_W'($urandom_range(0, 1)));
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int           phase_len, burst_left, msg_left, gap;
    logic         first;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // ---------------- directed part ----------------
    // Nonzero IV before any block: a non-first block chains with a zero
    // chain value, so it goes through unchanged by the XOR.
    write_reg(REG_CIPHER_KEY, 64'h0123_4567_89AB_CDEF);
    write_reg(REG_INIT_VECTOR, 64'hFEDC_BA98_7654_3210);
    cfg_we <= 1'b0;
    send_request(ALL_ONES, 1'b0);
    send_request('0, 1'b0);
    send_request(64'h0011_2233_4455_6677, 1'b1);
    send_request(64'h8000_0000_0000_0001, 1'b0);
    in_valid <= 1'b0;
    wait_drained();

    // Switch to decrypt mid-message: the chain carries the last ciphertext
    write_reg(REG_DECRYPT_MODE, CFG_DATA_W'(1));
    cfg_we <= 1'b0;
    send_request(64'hDEAD_BEEF_CAFE_F00D, 1'b0);
    send_request(ALL_ONES, 1'b1);
    send_request('0, 1'b0);
    in_valid <= 1'b0;
    wait_drained();

    // Round count zero acts as one; zero IV makes the first flag inert
    write_reg(REG_ROUND_COUNT, CFG_DATA_W'(0));
    write_reg(REG_INIT_VECTOR, '0);
    write_reg(REG_DECRYPT_MODE, CFG_DATA_W'(0));
    cfg_we <= 1'b0;
    send_request(64'hA5A5_A5A5_A5A5_A5A5, 1'b1);
    send_request(64'h5A5A_5A5A_5A5A_5A5A, 1'b0);
    in_valid <= 1'b0;
    wait_drained();

    // Full rounds with the all-ones key and IV
    write_reg(REG_CIPHER_KEY, ALL_ONES);
    write_reg(REG_ROUND_COUNT, CFG_DATA_W'(MAX_ROUNDS));
    write_reg(REG_INIT_VECTOR, ALL_ONES);
    cfg_we <= 1'b0;
    send_request('0, 1'b1);
    send_request(ALL_ONES, 1'b0);
    in_valid <= 1'b0;
    wait_drained();

    // Counts above the maximum saturate, here in decrypt mode
    write_reg(REG_ROUND_COUNT, CFG_DATA_W'(MAX_ROUNDS + 1));
    write_reg(REG_DECRYPT_MODE, CFG_DATA_W'(1));
    cfg_we <= 1'b0;
    send_request(64'h0123_4567_89AB_CDEF, 1'b1);
    send_request(64'hFEDC_BA98_7654_3210, 1'b0);
    in_valid <= 1'b0;
    wait_drained();

    write_reg(REG_ROUND_COUNT, CFG_DATA_W'(31));
    cfg_we <= 1'b0;
    send_request(64'h1357_9BDF_0246_8ACE, 1'b1);
    send_request(64'hFFFF_0000_FFFF_0000, 1'b0);
    in_valid <= 1'b0;
    wait_drained();

    // Single round, zero key, back to encrypt
    write_reg(REG_ROUND_COUNT, CFG_DATA_W'(1));
    write_reg(REG_CIPHER_KEY, '0);
    write_reg(REG_DECRYPT_MODE, CFG_DATA_W'(0));
    cfg_we <= 1'b0;
    send_request(64'h0000_0001_8000_0000, 1'b1);
    send_request(64'h7FFF_FFFF_FFFF_FFFE, 1'b0);
    in_valid <= 1'b0;

    // ---------------- random part ----------------
    // Each phase drains, rewrites some registers, then streams messages:
    // a first block followed by chained blocks, with a little noise in the
    // first flag. Bursts and gaps vary; now and then drain mid-phase.
    while (requests_sent < ITEM_TARGET) begin
      wait_drained();
      randomize_settings();
      phase_len  = $urandom_range(40, 120);
      burst_left = 0;
      msg_left   = 0;
      for (int n = 0; n < phase_len; n++) begin
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 24);
          if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst_left = $urandom_range(1, 24);
        end else if ($urandom_range(0, 59) == 0) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        if (msg_left == 0) begin
          first    = ($urandom_range(0, 9) != 0);
          msg_left = $urandom_range(1, 10);
        end else begin
          first = ($urandom_range(0, 19) == 0);
        end
        msg_left--;
        send_request(rand_block(), first);
        burst_left--;
      end
      in_valid <= 1'b0;
    end

    // Drain, then give the engine time to show any stray result
    wait_drained();
    repeat (4 * (MAX_ROUNDS + 2)) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: feistel_cbc_block_cipher_top.f
rtl/fcbc_pkg.sv
rtl/fcbc_queue.sv
rtl/fcbc_round.sv
rtl/fcbc_engine.sv
rtl/feistel_cbc_block_cipher_top.sv
rtl/fcbc_checker.sv
verif/fcbc_cipher_checker.sv
verif/feistel_cbc_block_cipher_top_test.sv
